/* rtl/d2rp_pkg.sv */
package d2rp_pkg;

  // Sizing of the name store and the label start table
  localparam int MAX_NAME_LEN = 256;
  localparam int MAX_DOTS     = 8;
  localparam int NL_AW        = $clog2(MAX_NAME_LEN);
  localparam int NL_W         = $clog2(MAX_NAME_LEN + 1);
  localparam int DC_W         = $clog2(MAX_DOTS + 2);
  localparam int SI_W         = $clog2(MAX_DOTS + 1);
  localparam int WORD_BYTES   = 8;

  // Character and limit constants
  localparam logic [7:0] LABEL_LIMIT = 8'd63;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_DASH     = 8'h2D;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NAME_LONG  = 3'd1,
    ST_LABEL_LONG = 3'd2,
    ST_DOTS       = 3'd3,
    ST_BAD_CHAR   = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // store and check the input beat
    logic err_out;     // issue the error result and clear the run
    logic lead;        // leading slash, load the top label
    logic emit_mem;    // read one stored byte of the open label
    logic emit_next;   // slash after a label, load the next lower label
    logic emit_final;  // final slash, clear the run
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic name_ok;     // the beat on the input ports would finish a clean name
    logic pos_lt_stop; // bytes remain in the open label
    logic lab_zero;    // the open label is the first one of the name
  } sts_t;

endpackage

/* rtl/d2rp_datapath.sv */
module d2rp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  d2rp_pkg::cmd_t       cmd,
  output d2rp_pkg::sts_t       sts,
  input  logic [7:0]           in_name_byte,
  input  logic                 in_end_of_name,
  output logic                 out_valid,
  output logic [63:0]          out_bytes,
  output logic [3:0]           out_byte_count,
  output logic [2:0]           out_status,
  output logic                 out_last_word
);
  import d2rp_pkg::*;

  // Run state
  logic [NL_W-1:0]  nl_r;
  logic [DC_W-1:0]  dc_r;
  logic [7:0]       cll_r;
  status_t          err_r;
  logic [NL_AW-1:0] starts_r [MAX_DOTS+1];
  logic [7:0]       mem [MAX_NAME_LEN];
  logic [7:0]       rd_data_r;

  // Label walk
  logic [NL_W-1:0]  pos_r;
  logic [NL_W-1:0]  stop_r;
  logic [NL_AW-1:0] lstart_r;
  logic [SI_W-1:0]  lab_r;

  // Byte stage and packer
  logic             s1_valid_r;
  logic             s1_slash_r;
  logic             s1_final_r;
  logic [63:0]      pack_r;
  logic [2:0]       pack_cnt_r;

  // Output register
  logic             out_valid_r;
  logic [63:0]      out_bytes_r;
  logic [3:0]       out_count_r;
  logic [2:0]       out_status_r;
  logic             out_last_r;

  logic             is_dot;
  logic             trailing;
  logic             legal;
  logic [DC_W:0]    dc_inc;
  logic [NL_W-1:0]  nl_inc;
  logic [NL_W:0]    raw_len;
  status_t          err_nxt;
  status_t          stat_c;
  logic [DC_W-1:0]  dc_nxt;
  logic [7:0]       cll_nxt;
  logic [NL_W-1:0]  nl_nxt;
  logic             st_wr;
  logic             mem_wr;
  logic [SI_W-1:0]  rd_idx;
  logic [NL_AW-1:0] start_rd;
  logic [7:0]       s1_byte;
  logic [63:0]      word_c;
  logic             flush;

  // Classify the incoming byte
  assign is_dot   = (in_name_byte == CH_DOT);
  assign trailing = in_end_of_name & is_dot;
  assign legal    = ((in_name_byte >= 8'h30) && (in_name_byte <= 8'h39)) ||
                    ((in_name_byte >= 8'h61) && (in_name_byte <= 8'h7A)) ||
                    (in_name_byte == CH_DASH);
  assign dc_inc   = {1'b0, dc_r} + (DC_W+1)'(1);
  assign nl_inc   = nl_r + NL_W'(1);

  // Next run state for a taken beat
  always_comb begin
    err_nxt = err_r;
    dc_nxt  = dc_r;
    cll_nxt = cll_r;
    nl_nxt  = nl_r;
    st_wr   = 1'b0;
    mem_wr  = 1'b0;
    if (!trailing) begin
      if (is_dot) begin
        if (err_r == ST_OK) begin
          if (cll_r > LABEL_LIMIT) begin
            err_nxt = ST_LABEL_LONG;
          end else if (dc_inc > (DC_W+1)'(MAX_DOTS)) begin
            err_nxt = ST_DOTS;
          end
        end
        if (dc_r <= DC_W'(MAX_DOTS)) begin
          dc_nxt = dc_inc[DC_W-1:0];
        end
        st_wr   = (dc_inc <= (DC_W+1)'(MAX_DOTS));
        cll_nxt = 8'd0;
      end else begin
        if ((err_r == ST_OK) && !legal) begin
          err_nxt = ST_BAD_CHAR;
        end
        if (cll_r != 8'hFF) begin
          cll_nxt = cll_r + 8'd1;
        end
      end
      if (nl_r < NL_W'(MAX_NAME_LEN)) begin
        mem_wr = 1'b1;
        nl_nxt = nl_inc;
      end
    end
  end

  // Final status if this beat closes the name
  assign raw_len = {1'b0, nl_nxt} + (NL_W+1)'(trailing);
  always_comb begin
    stat_c = err_nxt;
    if ((stat_c == ST_OK) && (cll_nxt > LABEL_LIMIT)) begin
      stat_c = ST_LABEL_LONG;
    end
    if (raw_len >= (NL_W+1)'(MAX_NAME_LEN)) begin
      stat_c = ST_NAME_LONG;
    end
  end

  // Label start lookup; the first label always starts at zero
  assign rd_idx   = cmd.lead ? dc_r[SI_W-1:0] : (lab_r - SI_W'(1));
  assign start_rd = (rd_idx == '0) ? '0 : starts_r[rd_idx];

  assign sts.name_ok     = (stat_c == ST_OK);
  assign sts.pos_lt_stop = (pos_r < stop_r);
  assign sts.lab_zero    = (lab_r == '0);

  // Hold run state; clear it after each name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_r  <= '0;
      dc_r  <= '0;
      cll_r <= '0;
      err_r <= ST_OK;
    end else if (cmd.err_out || cmd.emit_final) begin
      nl_r  <= '0;
      dc_r  <= '0;
      cll_r <= '0;
      err_r <= ST_OK;
    end else if (cmd.take) begin
      nl_r  <= nl_nxt;
      dc_r  <= dc_nxt;
      cll_r <= cll_nxt;
      err_r <= err_nxt;
    end
  end

  // Record label starts
  always_ff @(posedge clk) begin
    if (cmd.take && st_wr) begin
      starts_r[dc_inc[SI_W-1:0]] <= nl_inc[NL_AW-1:0];
    end
  end

  // Name store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && mem_wr) begin
      mem[nl_r[NL_AW-1:0]] <= in_name_byte;
    end
    rd_data_r <= mem[pos_r[NL_AW-1:0]];
  end

  // Walk the labels from last to first
  always_ff @(posedge clk) begin
    if (cmd.lead) begin
      lab_r    <= dc_r[SI_W-1:0];
      pos_r    <= NL_W'(start_rd);
      lstart_r <= start_rd;
      stop_r   <= nl_r;
    end else if (cmd.emit_mem) begin
      pos_r    <= pos_r + NL_W'(1);
    end else if (cmd.emit_next) begin
      lab_r    <= lab_r - SI_W'(1);
      stop_r   <= NL_W'(lstart_r) - NL_W'(1);
      pos_r    <= NL_W'(start_rd);
      lstart_r <= start_rd;
    end
  end

  // Byte stage, aligned with the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.lead | cmd.emit_mem | cmd.emit_next | cmd.emit_final;
    end
    s1_slash_r <= ~cmd.emit_mem;
    s1_final_r <= cmd.emit_final;
  end

  // Pack bytes into the word, lowest lane first
  assign s1_byte = s1_slash_r ? CH_SLASH : rd_data_r;
  always_comb begin
    word_c = pack_r;
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (pack_cnt_r == 3'(k)) begin
        word_c[8*k +: 8] = s1_byte;
      end
    end
  end
  assign flush = s1_valid_r & ((pack_cnt_r == 3'(WORD_BYTES - 1)) | s1_final_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r     <= '0;
      pack_cnt_r <= '0;
    end else if (s1_valid_r) begin
      if (flush) begin
        pack_r     <= '0;
        pack_cnt_r <= '0;
      end else begin
        pack_r     <= word_c;
        pack_cnt_r <= pack_cnt_r + 3'd1;
      end
    end
  end

  // Output register: error beat or packed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.err_out | flush;
    end
    if (cmd.err_out) begin
      out_bytes_r  <= '0;
      out_count_r  <= '0;
      out_status_r <= stat_c;
      out_last_r   <= 1'b1;
    end else if (flush) begin
      out_bytes_r  <= word_c;
      out_count_r  <= {1'b0, pack_cnt_r} + 4'd1;
      out_status_r <= ST_OK;
      out_last_r   <= s1_final_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = out_bytes_r;
  assign out_byte_count = out_count_r;
  assign out_status     = out_status_r;
  assign out_last_word  = out_last_r;

endmodule

/* rtl/d2rp_ctrl.sv */
module d2rp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           end_of_name,
  output logic           busy,
  input  d2rp_pkg::sts_t sts,
  output d2rp_pkg::cmd_t cmd
);
  import d2rp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEAD,
    S_BYTES,
    S_DRAIN
  } state_t;

  state_t state_r;
  logic   busy_r;

  // Decode commands from state and status
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take    = start;
        cmd.err_out = start & end_of_name & ~sts.name_ok;
      end
      S_LEAD: begin
        cmd.lead = 1'b1;
      end
      S_BYTES: begin
        priority if (sts.pos_lt_stop) begin
          cmd.emit_mem = 1'b1;
        end else if (sts.lab_zero) begin
          cmd.emit_final = 1'b1;
        end else begin
          cmd.emit_next = 1'b1;
        end
      end
      S_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  // Advance state; busy covers the whole emit pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start && end_of_name && sts.name_ok) begin
            state_r <= S_LEAD;
            busy_r  <= 1'b1;
          end
        end
        S_LEAD: begin
          state_r <= S_BYTES;
        end
        S_BYTES: begin
          if (!sts.pos_lt_stop && sts.lab_zero) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/domain_to_reversed_prefix.sv */
// Dotted domain name in, slash-led prefix with labels reversed out.
// Input: one name byte per beat on in_name_byte, taken when start is high
// and busy is low; in_end_of_name marks the final byte of a name.
// Output: out_valid strobes one result beat for exactly one cycle, carrying
// up to eight prefix bytes (first in bits 7..0), out_byte_count, out_status
// and out_last_word. The receiver cannot stall, so every beat is taken.
// Bytes other than the last are taken back to back, one per cycle.
// A name with an error gives one status beat, with out_last_word set, in the
// cycle after its last byte; busy stays low and the next name may follow.
// A clean name of L stored bytes gives L+2 prefix bytes in ceil((L+2)/8)
// beats. The emit pass walks the name store one byte per cycle through its
// single read port: busy rises after the last byte and holds to the end of
// the pass; a beat goes out once eight bytes or the final slash are packed.
// Synchronous reset clears the run counters, the emit sequencer and the
// output strobe; the name store is not cleared.
module domain_to_reversed_prefix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_name_byte,
  input  logic        in_end_of_name,
  output logic        out_valid,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic [2:0]  out_status,
  output logic        out_last_word
);
  import d2rp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  d2rp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .end_of_name (in_end_of_name),
    .busy        (busy),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Store, checks and packer
  d2rp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_name_byte   (in_name_byte),
    .in_end_of_name (in_end_of_name),
    .out_valid      (out_valid),
    .out_bytes      (out_bytes),
    .out_byte_count (out_byte_count),
    .out_status     (out_status),
    .out_last_word  (out_last_word)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import d2rp_pkg::*;

  typedef logic [7:0] name_bytes_t[$];

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    status_t     status;
    logic        last;
  } prefix_beat_t;

  // How the result of the name now being sent is to be judged
  typedef enum logic [1:0] {
    CHK_CALC,
    CHK_STATUS,
    CHK_TEXT
  } check_kind_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_ITEMS   = 110;
  localparam int NO_ODD       = -1;
  localparam int DIR_ROWS     = 26;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_name_byte;
  logic        in_end_of_name;
  logic        out_valid;
  logic [63:0] out_bytes;
  logic [3:0]  out_byte_count;
  logic [2:0]  out_status;
  logic        out_last_word;

  // Name tracker state
  logic [7:0]  name_mem [MAX_NAME_LEN];
  int unsigned name_len;
  int unsigned dot_seen;
  int unsigned label_len;
  int unsigned label_base [MAX_DOTS + 1];
  status_t     first_err;
  status_t     calc_status;
  name_bytes_t calc_prefix;

  prefix_beat_t beats_due[$];
  check_kind_t  chk_kind;
  status_t      chk_status;
  string        chk_text;
  int           idle_pct;
  int           mismatches;
  int           cycle_count = 0;

  domain_to_reversed_prefix DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_name_byte   (in_name_byte),
    .in_end_of_name (in_end_of_name),
    .out_valid      (out_valid),
    .out_bytes      (out_bytes),
    .out_byte_count (out_byte_count),
    .out_status     (out_status),
    .out_last_word  (out_last_word)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Track one name byte; at the last byte settle the status and build the prefix
  function automatic void absorb_name_byte(logic [7:0] c, logic eon);
    bit          trailing;
    int unsigned stop;
    trailing = eon && (c == CH_DOT);
    if (!trailing) begin
      if (c == CH_DOT) begin
        // label length is judged before the dot budget
        if (first_err == ST_OK) begin
          if (label_len > LABEL_LIMIT) first_err = ST_LABEL_LONG;
          else if (dot_seen + 1 > MAX_DOTS) first_err = ST_DOTS;
        end
        if (dot_seen <= MAX_DOTS) dot_seen++;
        if (dot_seen <= MAX_DOTS) label_base[dot_seen] = name_len + 1;
        label_len = 0;
      end else begin
        if (first_err == ST_OK &&
            !((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || c == CH_DASH))
          first_err = ST_BAD_CHAR;
        if (label_len < 255) label_len++;
      end
      // drop bytes past the end of the store
      if (name_len < MAX_NAME_LEN) begin
        name_mem[name_len] = c;
        name_len++;
      end
    end
    if (!eon) return;

    calc_status = first_err;
    if (calc_status == ST_OK && label_len > LABEL_LIMIT) calc_status = ST_LABEL_LONG;
    // an over-long name wins over anything seen earlier
    if (name_len + (trailing ? 1 : 0) >= MAX_NAME_LEN) calc_status = ST_NAME_LONG;

    calc_prefix = {};
    if (calc_status == ST_OK) begin
      calc_prefix.push_back(CH_SLASH);
      for (int lab = int'(dot_seen); lab >= 0; lab--) begin
        stop = (lab == int'(dot_seen)) ? name_len : label_base[lab + 1] - 1;
        for (int unsigned i = label_base[lab]; i < stop; i++)
          calc_prefix.push_back(name_mem[i]);
        calc_prefix.push_back(CH_SLASH);
      end
    end

    // clear run state for the next name
    name_len      = 0;
    dot_seen      = 0;
    label_len     = 0;
    first_err     = ST_OK;
    label_base[0] = 0;
  endfunction

  // Split a prefix into eight-byte beats, or queue a single status beat
  function automatic void queue_result(status_t st, name_bytes_t pfx);
    prefix_beat_t beat;
    int           n;
    if (st != ST_OK) begin
      beat = '{bytes: 64'd0, count: 4'd0, status: st, last: 1'b1};
      beats_due.push_back(beat);
      return;
    end
    for (int i = 0; i < pfx.size(); i += WORD_BYTES) begin
      n = (pfx.size() - i < WORD_BYTES) ? pfx.size() - i : WORD_BYTES;
      beat = '0;
      beat.status = ST_OK;
      for (int k = 0; k < n; k++) beat.bytes[8*k +: 8] = pfx[i + k];
      beat.count = 4'(n);
      beat.last  = (i + WORD_BYTES >= pfx.size());
      beats_due.push_back(beat);
    end
  endfunction

  function automatic void append_text(ref name_bytes_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Mostly clean names with random content; some broken ones
  function automatic name_bytes_t rand_name();
    name_bytes_t q;
    int          mode;
    int          labels;
    int          len;
    int          pick;
    mode   = $urandom_range(0, 99);
    labels = (mode < 6) ? $urandom_range(10, 11) :
             (mode < 40) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      if (l > 0) q.push_back(CH_DOT);
      len = (mode >= 6 && mode < 9 && l == labels - 1) ? 64 : $urandom_range(0, 5);
      for (int j = 0; j < len; j++) begin
        pick = $urandom_range(0, 36);
        q.push_back(pick < 10 ? 8'("0" + pick) :
                    pick < 36 ? 8'("a" + pick - 10) : CH_DASH);
      end
    end
    if (q.size() == 0) q.push_back("x");
    // corrupt one byte
    if (mode >= 9 && mode < 21) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    // add a trailing dot
    if (mode >= 21 && mode < 32) q.push_back(CH_DOT);
    return q;
  endfunction

  // Present one beat, idling first as the phase asks; return once taken
  task automatic send_beat(input logic [7:0] b, input logic eon);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_name_byte   <= b;
    in_end_of_name <= eon;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_name(input name_bytes_t q);
    for (int i = 0; i < q.size(); i++) send_beat(q[i], i == q.size() - 1);
  endtask

  // Hold off until every queued beat has shown, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Take accepted beats into the tracker and check result beats
  always @(posedge clk) begin : watch_ports
    prefix_beat_t exp_beat;
    name_bytes_t  txt;
    if (rst_n && start && !busy) begin
      absorb_name_byte(in_name_byte, in_end_of_name);
      if (in_end_of_name) begin
        case (chk_kind)
          CHK_STATUS: queue_result(chk_status, calc_prefix);
          CHK_TEXT: begin
            txt = {};
            append_text(txt, chk_text);
            queue_result(ST_OK, txt);
          end
          default: queue_result(calc_status, calc_prefix);
        endcase
      end
    end
    if (rst_n && out_valid) begin
      if (beats_due.size() == 0) begin
        $error("result beat with none due: out_bytes %h", out_bytes);
        mismatches++;
      end else begin
        exp_beat = beats_due.pop_front();
        if (out_bytes !== exp_beat.bytes) begin
          $error("out_bytes: expected %h, got %h", exp_beat.bytes, out_bytes);
          mismatches++;
        end
        if (out_byte_count !== exp_beat.count) begin
          $error("out_byte_count: expected %0d, got %0d", exp_beat.count, out_byte_count);
          mismatches++;
        end
        if (out_status !== exp_beat.status) begin
          $error("out_status: expected %0d, got %0d", exp_beat.status, out_status);
          mismatches++;
        end
        if (out_last_word !== exp_beat.last) begin
          $error("out_last_word: expected %0d, got %0d", exp_beat.last, out_last_word);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    name_bytes_t q;
    string       head;
    string       body;
    string       tail;
    string       text;
    string       seg31;
    int          reps;
    int          odd;
    int          sent;
    check_kind_t kind;
    status_t     st;

    seg31         = "abcdefghijklmnopqrstuvwxyz01234";
    mismatches    = 0;
    name_len      = 0;
    dot_seen      = 0;
    label_len     = 0;
    first_err     = ST_OK;
    label_base[0] = 0;
    calc_status   = ST_OK;
    idle_pct      = 0;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_name_byte   <= 8'd0;
    in_end_of_name <= 1'b0;
    chk_kind       <= CHK_CALC;
    chk_status     <= ST_OK;
    chk_text       <= "";
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed names: head, odd byte, body repeated, tail
    for (int r = 0; r < DIR_ROWS; r++) begin
      head = "";
      body = "";
      reps = 0;
      tail = "";
      odd  = NO_ODD;
      kind = CHK_CALC;
      st   = ST_OK;
      text = "";
      case (r)
        0:  begin head = "a";                   kind = CHK_TEXT; text = "/a/"; end
        1:  begin head = "a.b.c";               kind = CHK_TEXT; text = "/c/b/a/"; end
        2:  begin head = ".";                   kind = CHK_TEXT; text = "//"; end
        3:  begin head = "a.b.c.";              kind = CHK_TEXT; text = "/c/b/a/"; end
        4:  begin head = "..";                  kind = CHK_TEXT; text = "///"; end
        5:  begin head = "a..b";                kind = CHK_TEXT; text = "/b//a/"; end
        6:  begin head = "0189az-.-";           kind = CHK_TEXT; text = "/-/0189az-/"; end
        7:  begin head = "a/b";                 kind = CHK_STATUS; st = ST_BAD_CHAR; end
        8:  begin head = "9:";                  kind = CHK_STATUS; st = ST_BAD_CHAR; end
        9:  begin odd = 'h60;                   kind = CHK_STATUS; st = ST_BAD_CHAR; end
        10: begin head = "z{";                  kind = CHK_STATUS; st = ST_BAD_CHAR; end
        11: begin head = "A";                   kind = CHK_STATUS; st = ST_BAD_CHAR; end
        12: begin head = ",";                   kind = CHK_STATUS; st = ST_BAD_CHAR; end
        13: begin head = "a"; odd = 'h00;       kind = CHK_STATUS; st = ST_BAD_CHAR; end
        14: begin odd = 'hFF; tail = ".b";      kind = CHK_STATUS; st = ST_BAD_CHAR; end
        15: begin body = "a"; reps = 63; end
        16: begin body = "a"; reps = 64; tail = ".b";
                  kind = CHK_STATUS; st = ST_LABEL_LONG; end
        17: begin head = "b."; body = "a"; reps = 64;
                  kind = CHK_STATUS; st = ST_LABEL_LONG; end
        18: begin head = "a.b.c.d.e.f.g.h.i";
                  kind = CHK_TEXT; text = "/i/h/g/f/e/d/c/b/a/"; end
        19: begin head = "a.b.c.d.e.f.g.h.i.j"; kind = CHK_STATUS; st = ST_DOTS; end
        20: begin head = "A.........";          kind = CHK_STATUS; st = ST_BAD_CHAR; end
        21: begin head = "........"; body = "a"; reps = 64; tail = ".b";
                  kind = CHK_STATUS; st = ST_LABEL_LONG; end
        22: begin body = {seg31, "."}; reps = 7; tail = seg31; end
        23: begin body = {seg31, "."}; reps = 7; tail = {seg31, "5"};
                  kind = CHK_STATUS; st = ST_NAME_LONG; end
        24: begin body = {seg31, "."}; reps = 8;
                  kind = CHK_STATUS; st = ST_NAME_LONG; end
        25: begin head = "A"; body = {seg31, "."}; reps = 9;
                  kind = CHK_STATUS; st = ST_NAME_LONG; end
        default: ;
      endcase
      q = {};
      append_text(q, head);
      if (odd != NO_ODD) q.push_back(8'(odd));
      repeat (reps) append_text(q, body);
      append_text(q, tail);
      chk_kind   <= kind;
      chk_status <= st;
      chk_text   <= text;
      send_name(q);
    end
    drain();

    // Random names over three idle phases, pausing for results between them
    chk_kind <= CHK_CALC;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 1) ? 53 : (ph == 2) ? 13 : 0;
      sent     = 0;
      while (sent < RAND_ITEMS / 3) begin
        q = rand_name();
        send_name(q);
        sent += q.size();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/d2rp_pkg.sv
rtl/d2rp_datapath.sv
rtl/d2rp_ctrl.sv
rtl/domain_to_reversed_prefix.sv
verif/tb_top.sv
